[rtl/stq_pkg.sv]
// stq_pkg: shared types and constants of the sorted timeout queue
// holds item codes, cell control struct and state encoding
// no dependencies
`default_nettype none

package stq_pkg;

    // table size default and field widths
    localparam int DEF_ENTRIES = 16;
    localparam int DL_W        = 32;
    localparam int ID_W        = 4;
    localparam int TICK_W      = 64;

    // tick-done mark period and its residue counter width
    localparam int LOAD_PERIOD = 125;
    localparam int MOD_W       = $clog2(LOAD_PERIOD);

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - (ID_W + 1 + TICK_W + 1);

    // input item function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPLY,
        ST_POP
    } t_state;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_EVAL,
        CELL_INSERT,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [ID_W-1:0]       new_id;
        logic [DL_W-1:0]       new_deadline;
        logic [DL_W-1:0]       now;
        logic [DL_W-1:0]       new_dist;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/stq_cell.sv]
// stq_cell: one slot of the sorted timeout chain
// holds a deadline and id, compares against a broadcast request and
// passes prefix flags to its right neighbor; depends on stq_pkg
`default_nettype none

module stq_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire stq_pkg::t_cell_ctrl      i_ctrl,
    input  wire logic                     i_occ,
    input  wire logic                     i_tail,
    input  wire logic [stq_pkg::DL_W-1:0] i_left_deadline,
    input  wire logic [stq_pkg::ID_W-1:0] i_left_id,
    input  wire logic                     i_left_pre,
    input  wire logic                     i_left_any,
    input  wire logic [stq_pkg::DL_W-1:0] i_right_deadline,
    input  wire logic [stq_pkg::ID_W-1:0] i_right_id,
    output logic      [stq_pkg::DL_W-1:0] o_deadline,
    output logic      [stq_pkg::ID_W-1:0] o_id,
    output logic                          o_pre,
    output logic                          o_any
);
    import stq_pkg::*;

    logic [DL_W-1:0] r_deadline;
    logic [ID_W-1:0] r_id;
    logic            r_ge;
    logic            r_match;
    logic            r_pre;
    logic            r_any;

    logic [DL_W-1:0] w_dist;
    logic            w_ge;
    logic            w_match;

    // distance of the stored deadline from the current low count
    assign w_dist  = r_deadline - i_ctrl.now;
    assign w_ge    = i_occ && (i_ctrl.new_dist <= w_dist);
    assign w_match = i_occ && (r_id == i_ctrl.new_id);

    // compare flags and their ripple from the left, one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge    <= 1'b0;
            r_match <= 1'b0;
            r_pre   <= 1'b0;
            r_any   <= 1'b0;
        end else if (i_ctrl.op == CELL_EVAL) begin
            r_ge    <= w_ge;
            r_match <= w_match;
            r_pre   <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            r_pre   <= i_left_pre;
            r_any   <= i_left_any;
        end
    end

    // slot contents: shift right on insert, shift left on pop
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_occ || i_tail) begin
                    if (r_pre) begin
                        r_deadline <= i_left_deadline;
                        r_id       <= i_left_id;
                    end else if (r_ge || i_tail) begin
                        r_deadline <= i_ctrl.new_deadline;
                        r_id       <= i_ctrl.new_id;
                    end
                end
            end
            CELL_POP: begin
                r_deadline <= i_right_deadline;
                r_id       <= i_right_id;
            end
            default: begin
            end
        endcase
    end

    assign o_deadline = r_deadline;
    assign o_id       = r_id;
    assign o_pre      = r_pre | r_ge;
    assign o_any      = r_any | r_match;

endmodule

`default_nettype wire

[rtl/sorted_timeout_queue_unit.sv]
// sorted_timeout_queue_unit: top level of the sorted timeout queue
// sequencer, tick counter and result register around a chain of stq_cell
// depends on stq_pkg and stq_cell
//
//  port group  | dir | tdata (low bit up)                          | tuser | tlast
//  ------------+-----+---------------------------------------------+-------+------
//  i_s_*       | in  | has_target, timer_id, deadline, zero pad    | func  | -
//  o_m_*       | out | timer_id_res, accepted, tick_count,         | kind  | last
//              |     | load_mark, zero pad                         |       |
//
// a set item runs from accept to the next accept through these steps: compares
// in every cell, the position and duplicate flags rippling down the chain, one
// commit step, then the idle state that takes the next item. a tick item pops
// one expiry per head compare while the head is due, then sends its tick result.
// reset is synchronous active low, clears the count, tick counter and flags.
// a stalled result register holds the sequencer in place until it drains.
`default_nettype none

module sorted_timeout_queue_unit #(
    parameter int ENTRIES = stq_pkg::DEF_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // has_target[0], timer_id[4:1], deadline[36:5], zero pad
    input  wire logic [stq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[0]
    input  wire logic                          i_s_tuser,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // timer_id_res[3:0], accepted[4], tick_count[68:5], load_mark[69], zero pad
    output logic      [stq_pkg::M_TDATA_W-1:0] o_m_tdata,
    // kind[1:0]
    output logic      [1:0]                    o_m_tuser,
    output logic                               o_m_tlast,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready
);
    import stq_pkg::*;

    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SCAN_W = $clog2(ENTRIES);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(ENTRIES);

    // sequencer and table state
    t_state              r_state, n_state;
    logic [SCAN_W-1:0]   r_scan;
    logic [CNT_W-1:0]    r_count;
    logic [TICK_W-1:0]   r_tick;
    logic [MOD_W-1:0]    r_mod;

    // captured set request
    logic                r_has_target;
    logic [ID_W-1:0]     r_new_id;
    logic [DL_W-1:0]     r_new_dl;
    logic [DL_W-1:0]     r_new_dist;

    // result register
    logic                r_m_valid;
    t_kind               r_m_kind;
    logic [ID_W-1:0]     r_m_id;
    logic                r_m_acc;
    logic [TICK_W-1:0]   r_m_tick;
    logic                r_m_mark;
    logic                r_m_last;

    // chain wiring
    logic [DL_W-1:0]     w_deadline [ENTRIES];
    logic [ID_W-1:0]     w_id       [ENTRIES];
    logic [ENTRIES-1:0]  w_pre;
    logic [ENTRIES-1:0]  w_any;
    t_cell_ctrl          w_ctrl;

    // decoded input item
    logic                w_s_accept;
    logic                w_in_has_target;
    logic [ID_W-1:0]     w_in_id;
    logic [DL_W-1:0]     w_in_dl;

    // sequencer outputs
    logic                w_slot_free;
    logic                w_ok;
    logic                w_head_hit;
    logic                w_emit;
    t_kind               w_e_kind;
    logic [ID_W-1:0]     w_e_id;
    logic                w_e_acc;
    logic                w_e_mark;
    logic                w_e_last;
    t_cell_op            w_op;
    logic                w_cnt_inc;
    logic                w_cnt_dec;

    assign w_in_has_target = i_s_tdata[0];
    assign w_in_id         = i_s_tdata[ID_W:1];
    assign w_in_dl         = i_s_tdata[ID_W+DL_W:ID_W+1];
    assign w_s_accept      = i_s_tvalid && o_s_tready;

    assign w_slot_free = !r_m_valid || i_m_tready;
    assign w_ok        = r_has_target && (r_count != FULL_CNT) && !w_any[ENTRIES-1];
    assign w_head_hit  = (r_count != '0) && (w_deadline[0] == r_tick[DL_W-1:0]);

    // broadcast to the cells
    assign w_ctrl.op           = w_op;
    assign w_ctrl.new_id       = r_new_id;
    assign w_ctrl.new_deadline = r_new_dl;
    assign w_ctrl.now          = r_tick[DL_W-1:0];
    assign w_ctrl.new_dist     = r_new_dist;

    // chain of cells
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        logic [DL_W-1:0] w_l_dl, w_r_dl;
        logic [ID_W-1:0] w_l_id, w_r_id;
        logic            w_l_pre, w_l_any;

        if (gi == 0) begin : g_first
            assign w_l_dl  = '0;
            assign w_l_id  = '0;
            assign w_l_pre = 1'b0;
            assign w_l_any = 1'b0;
        end else begin : g_mid
            assign w_l_dl  = w_deadline[gi-1];
            assign w_l_id  = w_id[gi-1];
            assign w_l_pre = w_pre[gi-1];
            assign w_l_any = w_any[gi-1];
        end

        if (gi == ENTRIES - 1) begin : g_last
            assign w_r_dl = '0;
            assign w_r_id = '0;
        end else begin : g_inner
            assign w_r_dl = w_deadline[gi+1];
            assign w_r_id = w_id[gi+1];
        end

        stq_cell u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctrl           (w_ctrl),
            .i_occ            (CNT_W'(gi) < r_count),
            .i_tail           (CNT_W'(gi) == r_count),
            .i_left_deadline  (w_l_dl),
            .i_left_id        (w_l_id),
            .i_left_pre       (w_l_pre),
            .i_left_any       (w_l_any),
            .i_right_deadline (w_r_dl),
            .i_right_id       (w_r_id),
            .o_deadline       (w_deadline[gi]),
            .o_id             (w_id[gi]),
            .o_pre            (w_pre[gi]),
            .o_any            (w_any[gi])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_accept) begin
                    n_state = (i_s_tuser == FUNC_SET) ? ST_SCAN : ST_POP;
                end
            end
            ST_SCAN: begin
                if (r_scan == SCAN_LAST) n_state = ST_REPLY;
            end
            ST_REPLY: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            ST_POP: begin
                if (w_slot_free && !w_head_hit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_emit     = 1'b0;
        w_e_kind   = KIND_TICK;
        w_e_id     = '0;
        w_e_acc    = 1'b0;
        w_e_mark   = 1'b0;
        w_e_last   = 1'b0;
        w_op       = CELL_HOLD;
        w_cnt_inc  = 1'b0;
        w_cnt_dec  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_SCAN: begin
                if (r_scan == '0) w_op = CELL_EVAL;
            end
            ST_REPLY: begin
                if (w_slot_free) begin
                    w_emit    = 1'b1;
                    w_e_kind  = KIND_SET;
                    w_e_id    = r_new_id;
                    w_e_acc   = w_ok;
                    w_e_last  = 1'b1;
                    w_op      = w_ok ? CELL_INSERT : CELL_HOLD;
                    w_cnt_inc = w_ok;
                end
            end
            ST_POP: begin
                if (w_slot_free) begin
                    w_emit = 1'b1;
                    if (w_head_hit) begin
                        w_e_kind  = KIND_EXPIRY;
                        w_e_id    = w_id[0];
                        w_op      = CELL_POP;
                        w_cnt_dec = 1'b1;
                    end else begin
                        w_e_kind = KIND_TICK;
                        w_e_mark = (r_mod == '0);
                        w_e_last = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scan    <= '0;
            r_count   <= '0;
            r_tick    <= '0;
            r_mod     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // scan step counter
            if (w_s_accept) begin
                r_scan <= '0;
            end else if (r_state == ST_SCAN) begin
                r_scan <= r_scan + 1'b1;
            end

            // pending count
            if (w_cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (w_cnt_dec) begin
                r_count <= r_count - 1'b1;
            end

            // tick counter and its residue modulo the load period
            if (w_s_accept && (i_s_tuser == FUNC_TICK)) begin
                r_tick <= r_tick + 1'b1;
                if (r_tick[DL_W-1:0] == '1) begin
                    r_mod <= '0;
                end else if (r_mod == MOD_W'(LOAD_PERIOD - 1)) begin
                    r_mod <= '0;
                end else begin
                    r_mod <= r_mod + 1'b1;
                end
            end

            // result register valid
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_has_target <= w_in_has_target;
            r_new_id     <= w_in_id;
            r_new_dl     <= w_in_dl;
            r_new_dist   <= w_in_dl - r_tick[DL_W-1:0];
        end
        if (w_emit) begin
            r_m_kind <= w_e_kind;
            r_m_id   <= w_e_id;
            r_m_acc  <= w_e_acc;
            r_m_tick <= r_tick;
            r_m_mark <= w_e_mark;
            r_m_last <= w_e_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_m_mark, r_m_tick, r_m_acc, r_m_id};
    assign o_m_tuser  = r_m_kind;
    assign o_m_tlast  = r_m_last;

    // pending count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("pending count exceeds table size");

    // an accepted set grows the table by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_e_kind == KIND_SET && w_e_acc) |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted set did not add an entry");

    // an expiry removes exactly one entry
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_e_kind == KIND_EXPIRY) |=> r_count == $past(r_count) - 1'b1)
        else $error("expiry did not remove an entry");

    // expiry notices are never the final result of an item
    a_expiry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_EXPIRY) |-> !o_m_tlast)
        else $error("expiry notice marked last");

    // no new item is taken while a set or a tick is being resolved
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_REPLY || r_state == ST_POP) |-> !o_s_tready)
        else $error("input ready while busy");

endmodule

`default_nettype wire

[tb/sv/sorted_timeout_queue_unit_tb.sv]
// sorted_timeout_queue_unit_tb: self-checking bench for the sorted timeout queue
// predicts every set reply, expiry notice and tick-done result and checks each one
// depends on stq_pkg and sorted_timeout_queue_unit
`default_nettype none

module sorted_timeout_queue_unit_tb;
    import stq_pkg::*;

    localparam int TABLE_DEPTH    = DEF_ENTRIES;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    // one expected result item
    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic              acc;
        logic [TICK_W-1:0] count;
        logic              mark;
        logic              last;
    } t_timeout_result;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = FUNC_TICK;
    logic                 s_tvalid = 1'b0;
    wire logic            s_tready;
    wire logic [M_TDATA_W-1:0] m_tdata;
    wire logic [1:0]      m_tuser;
    wire logic            m_tlast;
    wire logic            m_tvalid;
    logic                 m_tready = 1'b0;

    // predicted table state
    logic [DL_W-1:0]   tbl_deadline [TABLE_DEPTH];
    logic [ID_W-1:0]   tbl_id       [TABLE_DEPTH];
    int                tbl_count  = 0;
    logic [TICK_W-1:0] tick_total = '0;

    t_timeout_result due_results [$];
    int  errors        = 0;
    bit  sender_steady = 1'b0;
    int  hold_req      = 0;

    sorted_timeout_queue_unit #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tlast (m_tlast),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit id_is_pending(logic [ID_W-1:0] id);
        for (int j = 0; j < tbl_count; j++) begin
            if (tbl_id[j] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    // random id not in the table, or -1 when every id is pending
    function automatic int free_id();
        int ids [$];
        for (int k = 0; k < (1 << ID_W); k++) begin
            if (!id_is_pending(k[ID_W-1:0])) ids.push_back(k);
        end
        if (ids.size() == 0) return -1;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DL_W-1:0] near_deadline(int offset);
        return tick_total[DL_W-1:0] + offset;
    endfunction

    // predict the results of one accepted item and update the table copy
    task automatic compute_timer_results(logic func, logic tgt, logic [ID_W-1:0] id,
                                         logic [DL_W-1:0] dl);
        logic [DL_W-1:0] now_low;
        logic [DL_W-1:0] dist_new;
        logic [DL_W-1:0] dist_old;
        int  pos;
        int  j;
        bit  ok;
        if (func == FUNC_SET) begin
            now_low = tick_total[DL_W-1:0];
            ok = tgt && (tbl_count < TABLE_DEPTH) && !id_is_pending(id);
            if (ok) begin
                dist_new = dl - now_low;
                pos = tbl_count;
                for (j = 0; j < tbl_count; j++) begin
                    dist_old = tbl_deadline[j] - now_low;
                    if (dist_new <= dist_old) begin
                        pos = j;
                        break;
                    end
                end
                for (j = tbl_count; j > pos; j--) begin
                    tbl_deadline[j] = tbl_deadline[j-1];
                    tbl_id[j]       = tbl_id[j-1];
                end
                tbl_deadline[pos] = dl;
                tbl_id[pos]       = id;
                tbl_count++;
            end
            due_results.push_back('{KIND_SET, id, ok, tick_total, 1'b0, 1'b1});
        end else begin
            tick_total = tick_total + 1;
            now_low = tick_total[DL_W-1:0];
            // pop head entries that are due now
            while (tbl_count > 0 && tbl_deadline[0] == now_low) begin
                due_results.push_back('{KIND_EXPIRY, tbl_id[0], 1'b0, tick_total,
                                        1'b0, 1'b0});
                for (j = 1; j < tbl_count; j++) begin
                    tbl_deadline[j-1] = tbl_deadline[j];
                    tbl_id[j-1]       = tbl_id[j];
                end
                tbl_count--;
            end
            due_results.push_back('{KIND_TICK, '0, 1'b0, tick_total,
                                    (now_low % LOAD_PERIOD) == 0, 1'b1});
        end
    endtask

    // offer one item after a random gap (none while the sender is steady), return at the edge it is accepted
    task automatic send_item(logic func, logic tgt, logic [ID_W-1:0] id,
                             logic [DL_W-1:0] dl);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {{(S_TDATA_W-DL_W-ID_W-1){1'b0}}, dl, id, tgt};
        s_tuser  <= func;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        compute_timer_results(func, tgt, id, dl);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)),
                  $urandom);
    endtask

    function automatic void check_field(string name, logic [TICK_W-1:0] want,
                                        logic [TICK_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // result side: random stalls, checks each accepted result item
    initial begin
        t_timeout_result want;
        int stall_left;
        int r;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result with no expectation: kind %0d tdata %0h",
                           m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", TICK_W'(want.kind), TICK_W'(m_tuser));
                    check_field("timer_id_res", TICK_W'(want.id), TICK_W'(m_tdata[3:0]));
                    check_field("accepted", TICK_W'(want.acc), TICK_W'(m_tdata[4]));
                    check_field("tick_count", want.count, m_tdata[68:5]);
                    check_field("load_mark", TICK_W'(want.mark), TICK_W'(m_tdata[69]));
                    check_field("last", TICK_W'(want.last), TICK_W'(m_tlast));
                end
            end
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 15) stall_left = $urandom_range(1, 3);
                else if (r < 18) stall_left = $urandom_range(10, 40);
            end
        end
    end

    // watchdog: too many cycles with no item moving on either side
    initial begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // rejected sets, a duplicate id and a single expiry
    task automatic test_rejects();
        send_item(FUNC_SET, 1'b0, 4'hf, 32'hffff_ffff);
        send_item(FUNC_SET, 1'b1, 4'h5, near_deadline(1));
        send_item(FUNC_SET, 1'b1, 4'h5, near_deadline(2));
        send_tick();
    endtask

    // fill every entry at one deadline, reject when full, then pop all on one tick
    task automatic test_full_table();
        logic [DL_W-1:0] dl;
        dl = near_deadline(3);
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            send_item(FUNC_SET, 1'b1, k[ID_W-1:0], dl);
        end
        send_item(FUNC_SET, 1'b1, 4'h7, dl + 1);
        repeat (3) send_tick();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        int id;
        sender_steady = 1'b1;
        hold_req = 300;
        for (int k = 0; k < 40; k++) begin
            if (k % 3 == 0) begin
                id = free_id();
                send_item(FUNC_SET, 1'b1,
                          ID_W'((id < 0) ? int'($urandom_range(0, 15)) : id),
                          near_deadline(int'($urandom_range(1, 6))));
            end else begin
                send_tick();
            end
        end
        sender_steady = 1'b0;
    endtask

    // mostly well-formed sets and ticks, some noise and duplicates
    task automatic test_random(int n_items);
        int r;
        int id;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) sender_steady = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_tick();
            end else if (r < 85) begin
                id = free_id();
                send_item(FUNC_SET, 1'b1,
                          ID_W'((id < 0) ? int'($urandom_range(0, 15)) : id),
                          near_deadline(int'($urandom_range(1, (r < 65) ? 24 : 6))));
            end else if (r < 94) begin
                send_item(FUNC_SET, 1'b0, ID_W'($urandom_range(0, 15)), $urandom);
            end else begin
                id = (tbl_count > 0) ? int'(tbl_id[$urandom_range(0, tbl_count - 1)])
                                     : int'($urandom_range(0, 15));
                send_item(FUNC_SET, 1'b1, ID_W'(id),
                          near_deadline(int'($urandom_range(1, 24))));
            end
        end
        sender_steady = 1'b0;
    endtask

    // entry due at the current count sits at the head until a full wrap and
    // holds back a matching entry behind it; far deadlines park at the tail
    task automatic test_wrap_hold();
        repeat (25) send_tick();
        send_item(FUNC_SET, 1'b1, ID_W'(free_id()), near_deadline(0));
        send_item(FUNC_SET, 1'b1, ID_W'(free_id()), near_deadline(1));
        send_item(FUNC_SET, 1'b1, ID_W'(free_id()), 32'hffff_ffff);
        send_item(FUNC_SET, 1'b1, ID_W'(free_id()), 32'h0000_0000);
        repeat (3) send_tick();
    endtask

    // test sequence
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_rejects();
        test_full_table();
        test_backpressure();
        test_random(255);
        test_wrap_hold();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
